// ----- rtl/sarp_pkg.sv -----
// ----------------------------------------------------------------------------
// sarp_pkg: shared types and constants of the servo angle ramp positioner
// Control word layout, microprogram ROM, operation and register codes.
// ----------------------------------------------------------------------------
package sarp_pkg;

  // Field widths of the item fields and configuration registers
  localparam int unsigned ANGLE_W = 17;
  localparam int unsigned SPEED_W = 18;
  localparam int unsigned DMS_W   = 16;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SET_ANGLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_TARGET = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK       = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PPD         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERTED    = 3'd6;

  // Divide by 1000 as a shift by 3 then a reciprocal multiply for /125.
  // The shifted product stays below 2^31, so a 32-bit reciprocal at 2^38 is exact.
  localparam int unsigned RECIP_PRE   = 3;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [63:0] RECIP_FULL  = ((64'd1 << RECIP_SHIFT) + 64'd124) / 64'd125;
  localparam logic [31:0] RECIP_MUL   = RECIP_FULL[31:0];
  localparam int unsigned PROD_W      = DMS_W + SPEED_W;
  localparam int unsigned QUO_W       = 25;

  // Microprogram actions
  localparam int unsigned ACT_W = 4;
  localparam logic [ACT_W-1:0] ACT_NOP    = 4'd0;
  localparam logic [ACT_W-1:0] ACT_TARGET = 4'd1;
  localparam logic [ACT_W-1:0] ACT_PROD   = 4'd2;
  localparam logic [ACT_W-1:0] ACT_RECIP  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_STEP   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_CLAMP  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_SUM    = 4'd6;
  localparam logic [ACT_W-1:0] ACT_MUL    = 4'd7;
  localparam logic [ACT_W-1:0] ACT_MAP    = 4'd8;
  localparam logic [ACT_W-1:0] ACT_EMIT   = 4'd9;

  // Sequencing kinds
  localparam int unsigned JMP_W = 3;
  localparam logic [JMP_W-1:0] JMP_NEXT     = 3'd0;
  localparam logic [JMP_W-1:0] JMP_GOTO     = 3'd1;
  localparam logic [JMP_W-1:0] JMP_COND     = 3'd2;
  localparam logic [JMP_W-1:0] JMP_DISPATCH = 3'd3;
  localparam logic [JMP_W-1:0] JMP_HOLD     = 3'd4;

  // Jump conditions
  localparam logic COND_SPEED_ZERO = 1'b0;
  localparam logic COND_EQUAL      = 1'b1;

  // Step addresses
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd0;
  localparam logic [STEP_W-1:0] STEP_TARGET   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_TICK     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_RECIP    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MOVE     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CLAMP    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SUM      = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MUL      = 4'd7;
  localparam logic [STEP_W-1:0] STEP_MAP      = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd9;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [JMP_W-1:0]  jmp;
    logic              cond;
    logic [STEP_W-1:0] tgt;
  } ctrl_word_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            speed_zero;
    logic            angle_equal;
    logic            emit_ok;
  } seq_status_t;

  // Microprogram ROM
  function automatic ctrl_word_t rom(input logic [STEP_W-1:0] pc);
    ctrl_word_t w;
    w = '{act: ACT_EMIT, jmp: JMP_HOLD, cond: COND_SPEED_ZERO, tgt: STEP_EMIT};
    unique case (pc)
      STEP_DISPATCH: w = '{ACT_NOP,    JMP_DISPATCH, COND_SPEED_ZERO, STEP_DISPATCH};
      STEP_TARGET:   w = '{ACT_TARGET, JMP_GOTO,     COND_SPEED_ZERO, STEP_EMIT};
      STEP_TICK:     w = '{ACT_PROD,   JMP_COND,     COND_SPEED_ZERO, STEP_EMIT};
      STEP_RECIP:    w = '{ACT_RECIP,  JMP_NEXT,     COND_SPEED_ZERO, STEP_DISPATCH};
      STEP_MOVE:     w = '{ACT_STEP,   JMP_COND,     COND_EQUAL,      STEP_EMIT};
      STEP_CLAMP:    w = '{ACT_CLAMP,  JMP_NEXT,     COND_SPEED_ZERO, STEP_DISPATCH};
      STEP_SUM:      w = '{ACT_SUM,    JMP_NEXT,     COND_SPEED_ZERO, STEP_DISPATCH};
      STEP_MUL:      w = '{ACT_MUL,    JMP_NEXT,     COND_SPEED_ZERO, STEP_DISPATCH};
      STEP_MAP:      w = '{ACT_MAP,    JMP_NEXT,     COND_SPEED_ZERO, STEP_DISPATCH};
      STEP_EMIT:     w = '{ACT_EMIT,   JMP_HOLD,     COND_SPEED_ZERO, STEP_EMIT};
      default:       w = '{ACT_EMIT,   JMP_HOLD,     COND_SPEED_ZERO, STEP_EMIT};
    endcase
    return w;
  endfunction

  // Entry step of each operation
  function automatic logic [STEP_W-1:0] op_entry(input logic [OP_W-1:0] op);
    logic [STEP_W-1:0] s;
    s = STEP_EMIT;
    unique case (op)
      OP_SET_ANGLE:  s = STEP_CLAMP;
      OP_SET_TARGET: s = STEP_TARGET;
      OP_TICK:       s = STEP_TICK;
      OP_UNUSED:     s = STEP_EMIT;
      default:       s = STEP_EMIT;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/servo_angle_ramp_pulse.sv -----
// ----------------------------------------------------------------------------
// servo_angle_ramp_pulse: RC servo positioner with slew-rate limited ramp
// Q8.8 angle clamp, pulse compare mapping and tick-driven ramp to a target.
// ----------------------------------------------------------------------------
// Sequencing: one microprogram step per cycle from input transfer to result
//   valid, holding at the emit step while the output register is full.
// Throughput: one item at a time; the next is taken the cycle after the
//   sequencer has parked its result in the output register; the output
//   register holds while downstream stalls.
// Reset: limits and pulse settings return to their defaults, angle, target
//   and speed clear to zero; no output is valid after reset.
// ----------------------------------------------------------------------------
module servo_angle_ramp_pulse #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tuser: operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  // tdata: angle_value[16:0], speed_value[34:17], delta_ms[50:35], zero fill
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser: compare_written[0], reached[1]
  output logic [1:0]  m_axis_tuser,
  // tdata: compare_value[15:0], current_angle[32:16], zero fill
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sarp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sarp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned AW   = sarp_pkg::ANGLE_W;
  localparam int unsigned ARGW = 27;  // angle plus or minus a full step
  localparam int unsigned SUMW = AW + 1;
  localparam int unsigned MULW = SUMW + sarp_pkg::PULSE_W + 1;
  localparam int unsigned TW   = MULW + 2;
  localparam int unsigned PW   = sarp_pkg::PULSE_W;

  // Configuration registers
  logic signed [AW-1:0] min_angle_q, max_angle_q, offset_q;
  logic [PW-1:0]        min_pulse_q, max_pulse_q, ppd_q;
  logic                 inverted_q;

  // Ramp state
  logic signed [AW-1:0]              angle_now_q, goal_q;
  logic [sarp_pkg::SPEED_W-1:0]      speed_q;

  // Item and datapath registers
  logic [sarp_pkg::OP_W-1:0]         op_q;
  logic [sarp_pkg::SPEED_W-1:0]      spd_in_q;
  logic [sarp_pkg::DMS_W-1:0]        dms_q;
  logic signed [ARGW-1:0]            arg_q;
  logic signed [SUMW-1:0]            sum_q;
  logic signed [MULW-1:0]            mul_q;
  logic [sarp_pkg::PROD_W-1:0]       prod_q;
  logic [sarp_pkg::QUO_W-1:0]        quo_q;
  logic [PW-1:0]                     cmp_q;
  logic                              written_q, reached_q;

  // Output register
  logic                              out_valid_q;
  logic [PW-1:0]                     out_cmp_q;
  logic                              out_wr_q, out_reached_q;
  logic signed [AW-1:0]              out_angle_q;

  // Control
  logic                              in_xfer, busy, emit_ok, emit_go;
  logic [sarp_pkg::ACT_W-1:0]        act;
  sarp_pkg::seq_status_t             status;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy;
  assign emit_ok       = !out_valid_q || m_axis_tready;
  assign emit_go       = (act == sarp_pkg::ACT_EMIT) && emit_ok;

  assign status.op          = op_q;
  assign status.speed_zero  = (speed_q == '0);
  assign status.angle_equal = (angle_now_q == goal_q);
  assign status.emit_ok     = emit_ok;

  sarp_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .status_i(status),
    .busy_o  (busy),
    .act_o   (act)
  );

  // Configuration writes, always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_angle_q <= '0;
      max_angle_q <= 17'sd46080;
      offset_q    <= '0;
      min_pulse_q <= 16'd500;
      max_pulse_q <= 16'd2500;
      ppd_q       <= 16'd11;
      inverted_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sarp_pkg::REG_MIN_ANGLE: min_angle_q <= $signed(cfg_data_i);
        sarp_pkg::REG_MAX_ANGLE: max_angle_q <= $signed(cfg_data_i);
        sarp_pkg::REG_OFFSET:    offset_q    <= $signed(cfg_data_i);
        sarp_pkg::REG_MIN_PULSE: min_pulse_q <= cfg_data_i[PW-1:0];
        sarp_pkg::REG_MAX_PULSE: max_pulse_q <= cfg_data_i[PW-1:0];
        sarp_pkg::REG_PPD:       ppd_q       <= cfg_data_i[PW-1:0];
        sarp_pkg::REG_INVERTED:  inverted_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp of the pending argument to the angle limits
  logic signed [ARGW-1:0] max_ext, min_ext;
  logic signed [AW-1:0]   clamp_val;
  assign max_ext = ARGW'(max_angle_q);
  assign min_ext = ARGW'(min_angle_q);
  always_comb begin
    if (arg_q > max_ext)      clamp_val = max_angle_q;
    else if (arg_q < min_ext) clamp_val = min_angle_q;
    else                      clamp_val = arg_q[AW-1:0];
  end

  // Target clamp, tested on angle plus offset
  logic signed [AW-1:0]   tgt_in;
  logic signed [SUMW-1:0] tgt_sum;
  logic signed [AW-1:0]   tgt_val;
  assign tgt_in  = arg_q[AW-1:0];
  assign tgt_sum = SUMW'(tgt_in) + SUMW'(offset_q);
  always_comb begin
    if (tgt_sum > SUMW'(max_angle_q))      tgt_val = max_angle_q;
    else if (tgt_sum < SUMW'(min_angle_q)) tgt_val = min_angle_q;
    else                                   tgt_val = tgt_in;
  end

  // Step of the ramp toward the goal
  logic signed [ARGW-1:0] now_ext, goal_ext, dlt_ext, cand_dn, cand_up;
  logic                   move_down, arrive;
  assign now_ext   = ARGW'(angle_now_q);
  assign goal_ext  = ARGW'(goal_q);
  assign dlt_ext   = $signed({{(ARGW - sarp_pkg::QUO_W){1'b0}}, quo_q});
  assign cand_dn   = now_ext - dlt_ext;
  assign cand_up   = now_ext + dlt_ext;
  assign move_down = angle_now_q > goal_q;
  assign arrive    = move_down ? (cand_dn <= goal_ext) : (cand_up >= goal_ext);

  // Divide the elapsed product by 1000
  logic [63 - 1:0] recip_prod;
  assign recip_prod = 63'(prod_q[sarp_pkg::PROD_W-1:sarp_pkg::RECIP_PRE])
                    * 63'(sarp_pkg::RECIP_MUL);

  // Pulse mapping, floor to whole ticks, clamp to the pulse limits
  logic signed [TW-1:0] base_s, t_s, p_s, pmax_s, pmin_s;
  logic [PW-1:0]        map_val;
  assign base_s = TW'($signed({1'b0, inverted_q ? max_pulse_q : min_pulse_q}))
                  <<< FRACTION_BITS;
  assign t_s    = inverted_q ? base_s - TW'(mul_q) : base_s + TW'(mul_q);
  assign p_s    = t_s >>> FRACTION_BITS;
  assign pmax_s = TW'($signed({1'b0, max_pulse_q}));
  assign pmin_s = TW'($signed({1'b0, min_pulse_q}));
  always_comb begin
    if (p_s > pmax_s)      map_val = max_pulse_q;
    else if (p_s < pmin_s) map_val = min_pulse_q;
    else                   map_val = p_s[PW-1:0];
  end

  // Ramp state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_now_q <= '0;
      goal_q      <= '0;
      speed_q     <= '0;
    end else begin
      if (act == sarp_pkg::ACT_CLAMP) angle_now_q <= clamp_val;
      if (act == sarp_pkg::ACT_TARGET) begin
        goal_q  <= tgt_val;
        speed_q <= spd_in_q;
      end
      if (act == sarp_pkg::ACT_STEP && !status.angle_equal && arrive) speed_q <= '0;
    end
  end

  // Item capture and datapath steps
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= s_axis_tuser;
      arg_q     <= ARGW'($signed(s_axis_tdata[16:0]));
      spd_in_q  <= s_axis_tdata[34:17];
      dms_q     <= s_axis_tdata[50:35];
      cmp_q     <= '0;
      written_q <= 1'b0;
      reached_q <= 1'b0;
    end else begin
      case (act)
        sarp_pkg::ACT_PROD:
          prod_q <= sarp_pkg::PROD_W'(dms_q) * sarp_pkg::PROD_W'(speed_q);
        sarp_pkg::ACT_RECIP:
          quo_q <= recip_prod[sarp_pkg::RECIP_SHIFT +: sarp_pkg::QUO_W];
        sarp_pkg::ACT_STEP: begin
          if (status.angle_equal) begin
            reached_q <= 1'b1;
          end else if (arrive) begin
            arg_q     <= goal_ext;
            reached_q <= 1'b1;
          end else begin
            arg_q <= move_down ? cand_dn : cand_up;
          end
        end
        sarp_pkg::ACT_SUM:
          sum_q <= SUMW'(angle_now_q) + SUMW'(offset_q);
        sarp_pkg::ACT_MUL:
          mul_q <= $signed({1'b0, ppd_q}) * sum_q;
        sarp_pkg::ACT_MAP: begin
          cmp_q     <= map_val;
          written_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register: load on emit, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_cmp_q     <= cmp_q;
      out_wr_q      <= written_q;
      out_reached_q <= reached_q;
      out_angle_q   <= angle_now_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_angle_q, out_cmp_q};
  assign m_axis_tuser  = {out_reached_q, out_wr_q};

  // Checks
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> m_axis_tvalid)
    else $error("emitted result not presented");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_wr_q) |-> out_cmp_q == '0)
    else $error("compare value set without a write");

  a_idle_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> act == sarp_pkg::ACT_NOP)
    else $error("datapath active while accepting an item");

endmodule

// ----- rtl/sarp_seq.sv -----
// ----------------------------------------------------------------------------
// sarp_seq: microprogram sequencer
// Step counter over the control ROM with conditional jumps and dispatch.
// ----------------------------------------------------------------------------
module sarp_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  sarp_pkg::seq_status_t            status_i,
  output logic                             busy_o,
  output logic [sarp_pkg::ACT_W-1:0]       act_o
);

  logic [sarp_pkg::STEP_W-1:0] pc_q, pc_d;
  logic                        busy_q, busy_d;
  sarp_pkg::ctrl_word_t        word;
  logic                        cond_hit;

  // Decode the current control word
  assign word     = sarp_pkg::rom(pc_q);
  assign cond_hit = (word.cond == sarp_pkg::COND_EQUAL) ? status_i.angle_equal
                                                        : status_i.speed_zero;

  // Select the next step
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (start_i) begin
        pc_d   = sarp_pkg::STEP_DISPATCH;
        busy_d = 1'b1;
      end
    end else begin
      unique case (word.jmp)
        sarp_pkg::JMP_NEXT:     pc_d = pc_q + 1'b1;
        sarp_pkg::JMP_GOTO:     pc_d = word.tgt;
        sarp_pkg::JMP_COND:     pc_d = cond_hit ? word.tgt : pc_q + 1'b1;
        sarp_pkg::JMP_DISPATCH: pc_d = sarp_pkg::op_entry(status_i.op);
        sarp_pkg::JMP_HOLD: begin
          if (status_i.emit_ok) begin
            pc_d   = sarp_pkg::STEP_DISPATCH;
            busy_d = 1'b0;
          end
        end
        default: begin
          pc_d   = sarp_pkg::STEP_DISPATCH;
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= sarp_pkg::STEP_DISPATCH;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;
  assign act_o  = busy_q ? word.act : sarp_pkg::ACT_NOP;

  // Checks
  a_pc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> pc_q == sarp_pkg::STEP_DISPATCH)
    else $error("step counter left home while idle");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= sarp_pkg::STEP_EMIT)
    else $error("step counter beyond the program");

  a_start_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && start_i) |=> (busy_q && pc_q == sarp_pkg::STEP_DISPATCH))
    else $error("accepted item did not enter dispatch");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for servo_angle_ramp_pulse
// Drives set-angle, set-target, tick and unused commands over the input
// stream, programs the limits and pulse mapping between phases, predicts
// every output word (compare value, write and reached flags, angle) and
// checks each received word in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRAC_BITS     = 8;
  localparam longint MS_PER_SEC = 1000;
  localparam int ANGLE_LIMIT   = 46080;
  localparam int SPEED_MAX     = 262143;
  localparam int DMS_MAX       = 65535;
  localparam int PULSE_MAX     = 65535;
  localparam int MAX_GAP       = 14;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int SETTLE_CYCLES = 16;

  // One predicted output word
  typedef struct packed {
    logic [sarp_pkg::PULSE_W-1:0] compare;
    logic                         written;
    logic                         reached;
    logic [sarp_pkg::ANGLE_W-1:0] angle;
  } servo_output_t;

  typedef logic signed [sarp_pkg::ANGLE_W-1:0] angle_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic [1:0]  s_axis_tuser;
  logic [55:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [1:0]  m_axis_tuser;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [sarp_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [sarp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // Settings as the block holds them
  angle_t                       lo_limit, hi_limit, trim;
  logic [sarp_pkg::PULSE_W-1:0] pulse_lo, pulse_hi, ticks_per_deg;
  logic                         invert;

  // Positioner state
  angle_t                       pos_now, pos_goal;
  logic [sarp_pkg::SPEED_W-1:0] ramp_speed;

  servo_output_t awaited_outputs[$];
  int unsigned   items_sent;
  int unsigned   outputs_seen;
  int unsigned   mismatch_count;
  int unsigned   source_calm, sink_calm, sink_hold;

  servo_angle_ramp_pulse #(
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Idle cycles before the next transfer, with stretches of back-to-back traffic
  function automatic int unsigned draw_gap(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Uniform value that lands on either bound now and then
  function automatic int pick_value(input int low, input int high);
    case ($urandom_range(0, 7))
      0: return low;
      1: return high;
      default: return low + int'($urandom_range(0, high - low));
    endcase
  endfunction

  // Clamp the angle into the limits, store it and map it to a compare value
  function automatic logic [sarp_pkg::PULSE_W-1:0] place_angle(input longint req);
    longint a, s, t, p;
    a = req;
    if (a > longint'(hi_limit)) begin
      a = longint'(hi_limit);
    end else if (a < longint'(lo_limit)) begin
      a = longint'(lo_limit);
    end
    pos_now = a[sarp_pkg::ANGLE_W-1:0];
    s = a + longint'(trim);
    if (invert) begin
      t = (longint'(pulse_hi) <<< FRAC_BITS) - longint'(ticks_per_deg) * s;
    end else begin
      t = (longint'(pulse_lo) <<< FRAC_BITS) + longint'(ticks_per_deg) * s;
    end
    p = t >>> FRAC_BITS;
    if (p > longint'(pulse_hi)) begin
      p = longint'(pulse_hi);
    end else if (p < longint'(pulse_lo)) begin
      p = longint'(pulse_lo);
    end
    return p[sarp_pkg::PULSE_W-1:0];
  endfunction

  // Apply one command to the positioner state and return the output word
  function automatic servo_output_t advance_servo(input logic [sarp_pkg::OP_W-1:0] op,
      input angle_t req, input logic [sarp_pkg::SPEED_W-1:0] spd,
      input logic [sarp_pkg::DMS_W-1:0] dms);
    servo_output_t r;
    longint sum, step;
    r = '0;
    case (op)
      sarp_pkg::OP_SET_ANGLE: begin
        r.compare = place_angle(longint'(req));
        r.written = 1'b1;
      end
      sarp_pkg::OP_SET_TARGET: begin
        sum = longint'(req) + longint'(trim);
        if (sum > longint'(hi_limit)) begin
          pos_goal = hi_limit;
        end else if (sum < longint'(lo_limit)) begin
          pos_goal = lo_limit;
        end else begin
          pos_goal = req;
        end
        ramp_speed = spd;
      end
      sarp_pkg::OP_TICK: begin
        if (ramp_speed != '0) begin
          step = (longint'(dms) * longint'(ramp_speed)) / MS_PER_SEC;
          if (pos_now > pos_goal) begin
            r.written = 1'b1;
            if (longint'(pos_now) - step <= longint'(pos_goal)) begin
              r.compare  = place_angle(longint'(pos_goal));
              ramp_speed = '0;
              r.reached  = 1'b1;
            end else begin
              r.compare = place_angle(longint'(pos_now) - step);
            end
          end else if (pos_now < pos_goal) begin
            r.written = 1'b1;
            if (longint'(pos_now) + step >= longint'(pos_goal)) begin
              r.compare  = place_angle(longint'(pos_goal));
              ramp_speed = '0;
              r.reached  = 1'b1;
            end else begin
              r.compare = place_angle(longint'(pos_now) + step);
            end
          end else begin
            r.reached = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.angle = pos_now;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatch_count++;
    $display("%0t output %0d: %s got %0d, want %0d", $time, outputs_seen, field, got, want);
  endtask

  // Send one command; valid stays high after the transfer so that the next
  // command may follow without a bubble
  task automatic send_command(input logic [sarp_pkg::OP_W-1:0] op, input int angle,
      input int speed, input int dms);
    int unsigned gap;
    logic [sarp_pkg::ANGLE_W-1:0] angle_bits;
    logic [sarp_pkg::SPEED_W-1:0] speed_bits;
    logic [sarp_pkg::DMS_W-1:0]   dms_bits;
    angle_bits = angle[sarp_pkg::ANGLE_W-1:0];
    speed_bits = speed[sarp_pkg::SPEED_W-1:0];
    dms_bits   = dms[sarp_pkg::DMS_W-1:0];
    gap = draw_gap(source_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, dms_bits, speed_bits, angle_bits};
    do @(posedge clk_i); while (!s_axis_tready);
    awaited_outputs.push_back(advance_servo(op, angle_bits, speed_bits, dms_bits));
    if (op != sarp_pkg::OP_UNUSED) begin
      items_sent++;
    end
  endtask

  // Hold the input stream until every predicted output has been received
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [sarp_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[sarp_pkg::CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sarp_pkg::REG_MIN_ANGLE: lo_limit      = value[sarp_pkg::ANGLE_W-1:0];
      sarp_pkg::REG_MAX_ANGLE: hi_limit      = value[sarp_pkg::ANGLE_W-1:0];
      sarp_pkg::REG_OFFSET:    trim          = value[sarp_pkg::ANGLE_W-1:0];
      sarp_pkg::REG_MIN_PULSE: pulse_lo      = value[sarp_pkg::PULSE_W-1:0];
      sarp_pkg::REG_MAX_PULSE: pulse_hi      = value[sarp_pkg::PULSE_W-1:0];
      sarp_pkg::REG_PPD:       ticks_per_deg = value[sarp_pkg::PULSE_W-1:0];
      sarp_pkg::REG_INVERTED:  invert        = value[0];
      default: begin
      end
    endcase
  endtask

  // Write all seven registers back to back; the block must be idle
  task automatic program_settings(input int min_a, input int max_a, input int offs,
      input int min_p, input int max_p, input int ppd, input int inv);
    write_reg(sarp_pkg::REG_MIN_ANGLE, min_a);
    write_reg(sarp_pkg::REG_MAX_ANGLE, max_a);
    write_reg(sarp_pkg::REG_OFFSET, offs);
    write_reg(sarp_pkg::REG_MIN_PULSE, min_p);
    write_reg(sarp_pkg::REG_MAX_PULSE, max_p);
    write_reg(sarp_pkg::REG_PPD, ppd);
    write_reg(sarp_pkg::REG_INVERTED, inv);
    cfg_valid_i <= 1'b0;
  endtask

  // Default settings: angle mapping, clamping, ignored and idle commands
  task automatic test_reset_defaults();
    send_command(sarp_pkg::OP_SET_ANGLE, 0, 0, 0);
    send_command(sarp_pkg::OP_SET_ANGLE, ANGLE_LIMIT, SPEED_MAX, DMS_MAX);
    send_command(sarp_pkg::OP_SET_ANGLE, -ANGLE_LIMIT, 0, 0);
    send_command(sarp_pkg::OP_UNUSED, -1, SPEED_MAX, DMS_MAX);
    send_command(sarp_pkg::OP_TICK, 0, 0, DMS_MAX);
    send_command(sarp_pkg::OP_SET_TARGET, 0, 3, 0);
    send_command(sarp_pkg::OP_TICK, 0, 0, 1000);
  endtask

  // Ramp up with a zero step, a partial step and arrival, then ramp down
  task automatic test_ramp_moves();
    send_command(sarp_pkg::OP_SET_TARGET, 2560, 256, 0);
    send_command(sarp_pkg::OP_TICK, 0, 0, 0);
    send_command(sarp_pkg::OP_TICK, 0, 0, 4000);
    send_command(sarp_pkg::OP_TICK, 0, 0, DMS_MAX);
    send_command(sarp_pkg::OP_SET_TARGET, -ANGLE_LIMIT, SPEED_MAX, 0);
    send_command(sarp_pkg::OP_TICK, 0, 0, 1);
    send_command(sarp_pkg::OP_TICK, 0, 0, DMS_MAX);
  endtask

  // Extreme and swapped settings, and a goal that the clamp never lets arrive
  task automatic test_extreme_settings();
    drain_outputs();
    program_settings(-ANGLE_LIMIT, ANGLE_LIMIT, ANGLE_LIMIT, 0, PULSE_MAX, PULSE_MAX, 1);
    send_command(sarp_pkg::OP_SET_ANGLE, -ANGLE_LIMIT, 0, 0);
    send_command(sarp_pkg::OP_SET_ANGLE, ANGLE_LIMIT, 0, 0);
    send_command(sarp_pkg::OP_SET_ANGLE, 1, 0, 0);
    drain_outputs();
    program_settings(ANGLE_LIMIT, -ANGLE_LIMIT, -ANGLE_LIMIT, PULSE_MAX, 0, 0, 0);
    send_command(sarp_pkg::OP_SET_ANGLE, 0, 0, 0);
    send_command(sarp_pkg::OP_SET_TARGET, ANGLE_LIMIT, SPEED_MAX, 0);
    send_command(sarp_pkg::OP_TICK, 0, 0, DMS_MAX);
    drain_outputs();
    program_settings(-1000, 1000, -1000, 500, 2500, 11, 0);
    send_command(sarp_pkg::OP_SET_ANGLE, 0, 0, 0);
    send_command(sarp_pkg::OP_SET_TARGET, 1500, 1000, 0);
    send_command(sarp_pkg::OP_TICK, 0, 0, 700);
    send_command(sarp_pkg::OP_TICK, 0, 0, 700);
    send_command(sarp_pkg::OP_TICK, 0, 0, 400);
  endtask

  // Optional set angle, a target, then ticks until arrival or a few tries
  task automatic run_ramp();
    int goal, speed, ticks;
    if ($urandom_range(0, 2) == 0) begin
      send_command(sarp_pkg::OP_SET_ANGLE, pick_value(-ANGLE_LIMIT, ANGLE_LIMIT),
                   pick_value(0, SPEED_MAX), pick_value(0, DMS_MAX));
    end
    case ($urandom_range(0, 3))
      0: goal = int'(pos_now);
      1: goal = pick_value(-ANGLE_LIMIT, ANGLE_LIMIT);
      default: goal = int'(pos_now) + int'($urandom_range(0, 8000)) - 4000;
    endcase
    if (goal > ANGLE_LIMIT) begin
      goal = ANGLE_LIMIT;
    end else if (goal < -ANGLE_LIMIT) begin
      goal = -ANGLE_LIMIT;
    end
    case ($urandom_range(0, 3))
      0: speed = pick_value(1, 400);
      1: speed = pick_value(400, 20000);
      2: speed = pick_value(0, SPEED_MAX);
      default: speed = pick_value(1, 4000);
    endcase
    send_command(sarp_pkg::OP_SET_TARGET, goal, speed, pick_value(0, DMS_MAX));
    ticks = $urandom_range(1, 14);
    while (ramp_speed != '0 && ticks != 0) begin
      send_command(sarp_pkg::OP_TICK, pick_value(-ANGLE_LIMIT, ANGLE_LIMIT),
                   pick_value(0, SPEED_MAX),
                   ($urandom_range(0, 5) == 0) ? pick_value(0, DMS_MAX) : pick_value(0, 60));
      ticks--;
    end
  endtask

  // Phases of random settings, each followed by ramps mixed with stray commands
  task automatic test_random_traffic();
    int unsigned stop_at, phase_end;
    int lo, hi, tmp;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      drain_outputs();
      lo = pick_value(-ANGLE_LIMIT, ANGLE_LIMIT);
      hi = pick_value(-ANGLE_LIMIT, ANGLE_LIMIT);
      if (lo > hi && $urandom_range(0, 3) != 0) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      program_settings(lo, hi,
        ($urandom_range(0, 3) == 0) ? pick_value(-ANGLE_LIMIT, ANGLE_LIMIT)
                                    : pick_value(-2000, 2000),
        pick_value(0, 3000), pick_value(1500, PULSE_MAX),
        ($urandom_range(0, 3) == 0) ? pick_value(0, PULSE_MAX) : pick_value(0, 60),
        int'($urandom_range(0, 1)));
      phase_end = items_sent + $urandom_range(60, 140);
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1: send_command(sarp_pkg::OP_W'($urandom_range(0, 3)),
                             pick_value(-ANGLE_LIMIT, ANGLE_LIMIT),
                             pick_value(0, SPEED_MAX), pick_value(0, DMS_MAX));
          2: send_command(sarp_pkg::OP_TICK, pick_value(-ANGLE_LIMIT, ANGLE_LIMIT),
                          pick_value(0, SPEED_MAX), pick_value(0, DMS_MAX));
          default: run_ramp();
        endcase
      end
    end
  endtask

  // Compare a received word with the oldest prediction
  task automatic check_output();
    servo_output_t want;
    logic [sarp_pkg::ANGLE_W-1:0] got_angle;
    outputs_seen++;
    if (awaited_outputs.size() == 0) begin
      report_mismatch("unexpected output, angle", longint'(angle_t'(m_axis_tdata[32:16])), 0);
      return;
    end
    want = awaited_outputs.pop_front();
    got_angle = m_axis_tdata[32:16];
    if (m_axis_tdata[15:0] !== want.compare) begin
      report_mismatch("compare_value", longint'(m_axis_tdata[15:0]), longint'(want.compare));
    end
    if (m_axis_tuser[0] !== want.written) begin
      report_mismatch("compare_written", longint'(m_axis_tuser[0]), longint'(want.written));
    end
    if (m_axis_tuser[1] !== want.reached) begin
      report_mismatch("reached", longint'(m_axis_tuser[1]), longint'(want.reached));
    end
    if (got_angle !== want.angle) begin
      report_mismatch("current_angle", longint'(angle_t'(got_angle)),
                      longint'(angle_t'(want.angle)));
    end
  endtask

  // Check every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_output();
    end
  end

  // Stall the output stream for a random number of cycles after each transfer
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sink_hold = draw_gap(sink_calm);
    end
    if (sink_hold != 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("servo_angle_ramp_pulse: mismatch");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= '0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    items_sent     = 0;
    outputs_seen   = 0;
    mismatch_count = 0;
    source_calm    = 0;
    sink_calm      = 0;
    sink_hold      = 0;
    lo_limit       = '0;
    hi_limit       = angle_t'(ANGLE_LIMIT);
    trim           = '0;
    pulse_lo       = 16'd500;
    pulse_hi       = 16'd2500;
    ticks_per_deg  = 16'd11;
    invert         = 1'b0;
    pos_now        = '0;
    pos_goal       = '0;
    ramp_speed     = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_ramp_moves();
    test_extreme_settings();
    test_random_traffic();

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_outputs.size() == 0) begin
      $display("servo_angle_ramp_pulse: match");
    end else begin
      $display("servo_angle_ramp_pulse: mismatch");
    end
    $finish;
  end

endmodule
